// ----- src/ipq_pkg.sv -----
// Shared types and constants of the indexed max-priority queue.
`default_nettype none
package ipq_pkg;

   localparam int QSIZE = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int KEY_W = 32;

   typedef enum logic [2:0] {
      FUNC_INSERT     = 3'd0,
      FUNC_CHANGE     = 3'd1,
      FUNC_REMOVE_MAX = 3'd2,
      FUNC_REMOVE_IDX = 3'd3,
      FUNC_QUERY      = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_BAD_INDEX = 3'd1,
      ERR_FULL      = 3'd2,
      ERR_PRESENT   = 3'd3,
      ERR_ABSENT    = 3'd4,
      ERR_EMPTY     = 3'd5
   } err_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_TK_G, ST_TK_L, ST_TK_K, ST_TK_M,
      ST_UP_RD, ST_UP_KRD, ST_UP_CMP,
      ST_DN_RD, ST_DN_K1, ST_DN_K2, ST_DN_SEL, ST_DN_CMP,
      ST_PLACE, ST_TOP, ST_TOP_K, ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [IDX_W-1:0] entry_index;
      logic [KEY_W-1:0] entry_key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] top_key;
      logic [IDX_W-1:0] top_index;
      logic [CNT_W-1:0] entry_count;
      logic             is_present;
      logic [2:0]       error_code;
   } rsp_type;

   typedef struct packed {
      logic    latch;
      logic    ins;
      logic    chg;
      logic    take_max;
      logic    take_idx;
      logic    err_we;
      err_type err;
      logic    rd_gone;
      logic    rd_last;
      logic    take_fix;
      logic    take_load;
      logic    up_rd;
      logic    up_krd;
      logic    up_move;
      logic    dn_rd;
      logic    dn_k1;
      logic    dn_k2;
      logic    dn_sel;
      logic    dn_move;
      logic    phase2;
      logic    place;
      logic    top_rd;
      logic    top_krd;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     cnt_zero;
      logic     cnt_full;
      logic     present;
      logic     p_root;
      logic     p_last;
      logic     dn_none;
      logic     dn_pair;
      logic     up_go;
      logic     dn_go;
      logic     moved;
      logic     second;
      logic     down_first;
   } sts_type;

endpackage
`default_nettype wire

// ----- src/indexed_max_priority_queue_unit.sv -----
// Top level of the indexed max-priority queue: sequencer plus datapath.
//  channel   ports                         handshake
//  request   start, busy, req_data         taken when start & !busy
//  result    rsp_strobe, rsp_data          one cycle per request, no stall
// One request at a time; a query or a rejected request passes through CHECK, TOP, TOP_K
// and OUT, where the result strobe is raised. A heap update reads and compares one parent
// or child level after another, fetching the last entry first on a removal and closing the
// sift at the end; each step is set by the single read port of each memory.
// Synchronous reset empties the queue at once; no clearing pass.
// The receiver cannot stall results.
`default_nettype none
module indexed_max_priority_queue_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ipq_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output ipq_pkg::rsp_type      rsp_data
);

   ipq_pkg::cmd_type cmd;
   ipq_pkg::sts_type sts;

   ipq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ipq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- src/ipq_ctrl.sv -----
// Sequencer of the indexed max-priority queue.
`default_nettype none
module ipq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire ipq_pkg::sts_type sts,
   output ipq_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   ipq_pkg::state_type state_ff, state_in;
   ipq_pkg::state_type stop_st, first_st, second_st;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      first_st  = sts.down_first ? ipq_pkg::ST_DN_RD : ipq_pkg::ST_UP_RD;
      second_st = sts.down_first ? ipq_pkg::ST_UP_RD : ipq_pkg::ST_DN_RD;
      stop_st   = (sts.moved || sts.second) ? ipq_pkg::ST_PLACE : second_st;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipq_pkg::ST_IDLE: if (start) state_in = ipq_pkg::ST_CHECK;
         ipq_pkg::ST_CHECK: begin
            case (sts.func)
               ipq_pkg::FUNC_INSERT:
                  state_in = (sts.cnt_full || sts.present) ? ipq_pkg::ST_TOP
                                                           : ipq_pkg::ST_UP_RD;
               ipq_pkg::FUNC_CHANGE:
                  state_in = sts.present ? ipq_pkg::ST_UP_RD : ipq_pkg::ST_TOP;
               ipq_pkg::FUNC_REMOVE_MAX:
                  state_in = sts.cnt_zero ? ipq_pkg::ST_TOP : ipq_pkg::ST_TK_G;
               ipq_pkg::FUNC_REMOVE_IDX:
                  state_in = sts.present ? ipq_pkg::ST_TK_G : ipq_pkg::ST_TOP;
               default: state_in = ipq_pkg::ST_TOP;
            endcase
         end
         ipq_pkg::ST_TK_G: state_in = ipq_pkg::ST_TK_L;
         ipq_pkg::ST_TK_L: state_in = ipq_pkg::ST_TK_K;
         ipq_pkg::ST_TK_K: state_in = sts.p_last ? ipq_pkg::ST_TOP : ipq_pkg::ST_TK_M;
         ipq_pkg::ST_TK_M: state_in = first_st;
         ipq_pkg::ST_UP_RD: state_in = sts.p_root ? stop_st : ipq_pkg::ST_UP_KRD;
         ipq_pkg::ST_UP_KRD: state_in = ipq_pkg::ST_UP_CMP;
         ipq_pkg::ST_UP_CMP: state_in = sts.up_go ? ipq_pkg::ST_UP_RD : stop_st;
         ipq_pkg::ST_DN_RD: state_in = sts.dn_none ? stop_st : ipq_pkg::ST_DN_K1;
         ipq_pkg::ST_DN_K1: state_in = ipq_pkg::ST_DN_K2;
         ipq_pkg::ST_DN_K2: state_in = sts.dn_pair ? ipq_pkg::ST_DN_SEL : ipq_pkg::ST_DN_CMP;
         ipq_pkg::ST_DN_SEL: state_in = ipq_pkg::ST_DN_CMP;
         ipq_pkg::ST_DN_CMP: state_in = sts.dn_go ? ipq_pkg::ST_DN_RD : stop_st;
         ipq_pkg::ST_PLACE: state_in = ipq_pkg::ST_TOP;
         ipq_pkg::ST_TOP: state_in = ipq_pkg::ST_TOP_K;
         ipq_pkg::ST_TOP_K: state_in = ipq_pkg::ST_OUT;
         ipq_pkg::ST_OUT: state_in = ipq_pkg::ST_IDLE;
         default: state_in = ipq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.err    = ipq_pkg::ERR_OK;
      busy       = (state_ff != ipq_pkg::ST_IDLE);
      rsp_strobe = (state_ff == ipq_pkg::ST_OUT);
      case (state_ff)
         ipq_pkg::ST_IDLE: cmd.latch = start;
         ipq_pkg::ST_CHECK: begin
            case (sts.func)
               ipq_pkg::FUNC_INSERT: begin
                  if (sts.cnt_full) begin
                     cmd.err_we = 1'b1;
                     cmd.err    = ipq_pkg::ERR_FULL;
                  end else if (sts.present) begin
                     cmd.err_we = 1'b1;
                     cmd.err    = ipq_pkg::ERR_PRESENT;
                  end else begin
                     cmd.ins = 1'b1;
                  end
               end
               ipq_pkg::FUNC_CHANGE: begin
                  if (sts.present) begin
                     cmd.chg = 1'b1;
                  end else begin
                     cmd.err_we = 1'b1;
                     cmd.err    = ipq_pkg::ERR_ABSENT;
                  end
               end
               ipq_pkg::FUNC_REMOVE_MAX: begin
                  if (sts.cnt_zero) begin
                     cmd.err_we = 1'b1;
                     cmd.err    = ipq_pkg::ERR_EMPTY;
                  end else begin
                     cmd.take_max = 1'b1;
                  end
               end
               ipq_pkg::FUNC_REMOVE_IDX: begin
                  if (sts.present) begin
                     cmd.take_idx = 1'b1;
                  end else begin
                     cmd.err_we = 1'b1;
                     cmd.err    = ipq_pkg::ERR_ABSENT;
                  end
               end
               default: cmd.err_we = 1'b0;
            endcase
         end
         ipq_pkg::ST_TK_G: cmd.rd_gone = 1'b1;
         ipq_pkg::ST_TK_L: cmd.rd_last = 1'b1;
         ipq_pkg::ST_TK_K: cmd.take_fix = 1'b1;
         ipq_pkg::ST_TK_M: cmd.take_load = 1'b1;
         ipq_pkg::ST_UP_RD: begin
            cmd.up_rd  = !sts.p_root;
            cmd.phase2 = sts.p_root && !(sts.moved || sts.second);
         end
         ipq_pkg::ST_UP_KRD: cmd.up_krd = 1'b1;
         ipq_pkg::ST_UP_CMP: begin
            cmd.up_move = sts.up_go;
            cmd.phase2  = !sts.up_go && !(sts.moved || sts.second);
         end
         ipq_pkg::ST_DN_RD: begin
            cmd.dn_rd  = !sts.dn_none;
            cmd.phase2 = sts.dn_none && !(sts.moved || sts.second);
         end
         ipq_pkg::ST_DN_K1: cmd.dn_k1 = 1'b1;
         ipq_pkg::ST_DN_K2: cmd.dn_k2 = 1'b1;
         ipq_pkg::ST_DN_SEL: cmd.dn_sel = 1'b1;
         ipq_pkg::ST_DN_CMP: begin
            cmd.dn_move = sts.dn_go;
            cmd.phase2  = !sts.dn_go && !(sts.moved || sts.second);
         end
         ipq_pkg::ST_PLACE: cmd.place = 1'b1;
         ipq_pkg::ST_TOP: cmd.top_rd = 1'b1;
         ipq_pkg::ST_TOP_K: cmd.top_krd = 1'b1;
         default: cmd.latch = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

// ----- src/ipq_datapath.sv -----
// Heap memories, key store, position map and working registers of the queue.
`default_nettype none
module ipq_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ipq_pkg::req_type req_data,
   input  wire ipq_pkg::cmd_type cmd,
   output ipq_pkg::sts_type      sts,
   output ipq_pkg::rsp_type      rsp_data
);

   logic [ipq_pkg::KEY_W-1:0] key_mem [ipq_pkg::QSIZE];
   logic [ipq_pkg::IDX_W-1:0] heap_mem [ipq_pkg::QSIZE];
   logic [ipq_pkg::CNT_W-1:0] pos_mem [ipq_pkg::QSIZE];
   logic [ipq_pkg::QSIZE-1:0] posv_ff;

   logic [2:0]                func_ff;
   logic [ipq_pkg::IDX_W-1:0] idx_ff, mi_ff, ci_ff, gone_ff;
   logic [ipq_pkg::KEY_W-1:0] key_ff, mk_ff, ck_ff, key_q_ff;
   logic [ipq_pkg::IDX_W-1:0] heap_q_ff;
   logic [ipq_pkg::CNT_W-1:0] pos_q_ff, count_ff, p_ff;
   logic [ipq_pkg::CNT_W:0]   c_ff;
   ipq_pkg::err_type          err_ff;
   logic                      moved_ff, second_ff, dfirst_ff;

   logic                      heap_rd, heap_we, pos_we, key_rd;
   logic [ipq_pkg::IDX_W-1:0] heap_ra, heap_wa, heap_wd, pos_wa;
   logic [ipq_pkg::CNT_W-1:0] p_m1, ph_m1, cnt_m1;
   logic [ipq_pkg::CNT_W:0]   p_x2;

   always_comb begin
      p_m1    = p_ff - 1'b1;
      ph_m1   = (p_ff >> 1) - 1'b1;
      cnt_m1  = count_ff - 1'b1;
      p_x2    = {p_ff, 1'b0};
      heap_rd = cmd.rd_gone | cmd.rd_last | cmd.up_rd | cmd.dn_rd | cmd.dn_k1 | cmd.top_rd;
      heap_ra = '0;
      if (cmd.rd_gone) heap_ra = p_m1[ipq_pkg::IDX_W-1:0];
      if (cmd.rd_last) heap_ra = cnt_m1[ipq_pkg::IDX_W-1:0];
      if (cmd.up_rd)   heap_ra = ph_m1[ipq_pkg::IDX_W-1:0];
      if (cmd.dn_rd)   heap_ra = {p_m1[ipq_pkg::IDX_W-2:0], 1'b1};
      if (cmd.dn_k1)   heap_ra = c_ff[ipq_pkg::IDX_W-1:0];
      heap_we = cmd.up_move | cmd.dn_move | cmd.place;
      heap_wa = p_m1[ipq_pkg::IDX_W-1:0];
      heap_wd = cmd.up_move ? heap_q_ff : (cmd.dn_move ? ci_ff : mi_ff);
      pos_we  = heap_we;
      pos_wa  = heap_wd;
      key_rd  = cmd.up_krd | cmd.dn_k1 | cmd.dn_k2 | cmd.take_fix | cmd.top_krd;
   end

   always_ff @(posedge clock) begin
      if (cmd.ins || cmd.chg) key_mem[idx_ff] <= key_ff;
      if (key_rd) key_q_ff <= key_mem[heap_q_ff];
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      if (heap_rd) heap_q_ff <= heap_mem[heap_ra];
      if (pos_we) pos_mem[pos_wa] <= p_ff;
      if (cmd.latch) pos_q_ff <= pos_mem[req_data.entry_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         posv_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pos_we) posv_ff[pos_wa] <= 1'b1;
         if (cmd.take_fix) posv_ff[gone_ff] <= 1'b0;
         if (cmd.ins) count_ff <= count_ff + 1'b1;
         if (cmd.take_fix) count_ff <= cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_data.func;
         idx_ff    <= req_data.entry_index;
         key_ff    <= req_data.entry_key;
         err_ff    <= ipq_pkg::ERR_OK;
         moved_ff  <= 1'b0;
         second_ff <= 1'b0;
      end
      if (cmd.err_we) err_ff <= cmd.err;
      if (cmd.ins || cmd.chg) begin
         mi_ff     <= idx_ff;
         mk_ff     <= key_ff;
         dfirst_ff <= 1'b0;
         p_ff      <= cmd.ins ? count_ff + 1'b1 : pos_q_ff;
      end
      if (cmd.take_max || cmd.take_idx) begin
         dfirst_ff <= 1'b1;
         p_ff      <= cmd.take_max ? ipq_pkg::CNT_W'(1) : pos_q_ff;
      end
      if (cmd.rd_last) gone_ff <= heap_q_ff;
      if (cmd.take_fix) mi_ff <= heap_q_ff;
      if (cmd.take_load) mk_ff <= key_q_ff;
      if (cmd.up_move) begin
         p_ff     <= p_ff >> 1;
         moved_ff <= 1'b1;
      end
      if (cmd.dn_rd) c_ff <= p_x2;
      if (cmd.dn_k1) ci_ff <= heap_q_ff;
      if (cmd.dn_k2) ck_ff <= key_q_ff;
      if (cmd.dn_sel && (ck_ff < key_q_ff)) begin
         ci_ff <= heap_q_ff;
         ck_ff <= key_q_ff;
         c_ff  <= c_ff + 1'b1;
      end
      if (cmd.dn_move) begin
         p_ff     <= c_ff[ipq_pkg::CNT_W-1:0];
         moved_ff <= 1'b1;
      end
      if (cmd.phase2) second_ff <= 1'b1;
   end

   always_comb begin
      sts.func       = ipq_pkg::func_type'(func_ff);
      sts.cnt_zero   = (count_ff == '0);
      sts.cnt_full   = (count_ff >= ipq_pkg::CNT_W'(ipq_pkg::QSIZE));
      sts.present    = posv_ff[idx_ff];
      sts.p_root     = (p_ff == ipq_pkg::CNT_W'(1));
      sts.p_last     = (p_ff == count_ff);
      sts.dn_none    = (p_x2 > {1'b0, count_ff});
      sts.dn_pair    = (c_ff < {1'b0, count_ff});
      sts.up_go      = (key_q_ff < mk_ff);
      sts.dn_go      = (mk_ff < ck_ff);
      sts.moved      = moved_ff;
      sts.second     = second_ff;
      sts.down_first = dfirst_ff;
   end

   always_comb begin
      rsp_data.top_key     = sts.cnt_zero ? '0 : key_q_ff;
      rsp_data.top_index   = sts.cnt_zero ? '0 : heap_q_ff;
      rsp_data.entry_count = count_ff;
      rsp_data.is_present  = posv_ff[idx_ff];
      rsp_data.error_code  = err_ff;
   end

endmodule
`default_nettype wire

// ----- test/tb_indexed_max_priority_queue_unit.sv -----
// Testbench of the indexed max-priority queue: directed table and random requests.
`default_nettype none
module tb_indexed_max_priority_queue_unit;

   localparam int WATCHDOG = 5000;
   localparam int NUM_RANDOM = 560;
   localparam logic [2:0] FUNC_SPARE = 3'd6;
   localparam logic [2:0] FUNC_TOP_CODE = 3'd7;

   typedef struct {
      logic [2:0]                func;
      logic [ipq_pkg::IDX_W-1:0] idx;
      logic [ipq_pkg::KEY_W-1:0] key;
      bit                        typed;
      ipq_pkg::rsp_type          rsp;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ipq_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   ipq_pkg::rsp_type rsp_data;

   logic [ipq_pkg::KEY_W-1:0] key_of[ipq_pkg::QSIZE];
   logic [ipq_pkg::IDX_W-1:0] slot_of[ipq_pkg::QSIZE+1];
   int                        pos_of[ipq_pkg::QSIZE];
   int                        live;

   ipq_pkg::rsp_type results_due[$];
   ipq_pkg::rsp_type typed_due[$];
   bit               typed_flag[$];
   int               mismatches = 0;
   int               requests_done = 0;
   int               results_seen = 0;
   int               quiet_cycles = 0;
   int               err_hits[8];

   indexed_max_priority_queue_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit lower(int a, int b);
      return key_of[slot_of[a]] < key_of[slot_of[b]];
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [ipq_pkg::IDX_W-1:0] ia;
      logic [ipq_pkg::IDX_W-1:0] ib;
      ia = slot_of[a];
      ib = slot_of[b];
      slot_of[a] = ib;
      slot_of[b] = ia;
      pos_of[ia] = b;
      pos_of[ib] = a;
   endfunction

   function automatic int sift_up(int p);
      while (p > 1 && lower(p / 2, p)) begin
         swap_slots(p / 2, p);
         p = p / 2;
      end
      return p;
   endfunction

   function automatic void sift_down(int p);
      int c;
      while (2 * p <= live) begin
         c = 2 * p;
         if (c < live && lower(c, c + 1)) c++;
         if (!lower(p, c)) break;
         swap_slots(p, c);
         p = c;
      end
   endfunction

   function automatic void remove_at(int p);
      logic [ipq_pkg::IDX_W-1:0] gone;
      logic [ipq_pkg::IDX_W-1:0] last;
      int                        q;
      gone = slot_of[p];
      last = slot_of[live];
      slot_of[p] = last;
      pos_of[last] = p;
      pos_of[gone] = 0;
      live--;
      if (p <= live) begin
         sift_down(p);
         q = sift_up(p);
      end
   endfunction

   function automatic ipq_pkg::rsp_type heap_apply(logic [2:0] func,
                                                   logic [ipq_pkg::IDX_W-1:0] idx,
                                                   logic [ipq_pkg::KEY_W-1:0] key);
      ipq_pkg::rsp_type r;
      ipq_pkg::err_type e;
      int               q;
      e = ipq_pkg::ERR_OK;
      case (func)
         ipq_pkg::FUNC_INSERT: begin
            if (live >= ipq_pkg::QSIZE) e = ipq_pkg::ERR_FULL;
            else if (pos_of[idx] != 0) e = ipq_pkg::ERR_PRESENT;
            else begin
               live++;
               key_of[idx] = key;
               slot_of[live] = idx;
               pos_of[idx] = live;
               q = sift_up(live);
            end
         end
         ipq_pkg::FUNC_CHANGE: begin
            if (pos_of[idx] == 0) e = ipq_pkg::ERR_ABSENT;
            else begin
               key_of[idx] = key;
               sift_down(sift_up(pos_of[idx]));
            end
         end
         ipq_pkg::FUNC_REMOVE_MAX: begin
            if (live == 0) e = ipq_pkg::ERR_EMPTY;
            else remove_at(1);
         end
         ipq_pkg::FUNC_REMOVE_IDX: begin
            if (pos_of[idx] == 0) e = ipq_pkg::ERR_ABSENT;
            else remove_at(pos_of[idx]);
         end
         default: ;
      endcase
      r.top_key = (live > 0) ? key_of[slot_of[1]] : '0;
      r.top_index = (live > 0) ? slot_of[1] : '0;
      r.entry_count = live[ipq_pkg::CNT_W-1:0];
      r.is_present = (pos_of[idx] != 0);
      r.error_code = e;
      err_hits[e]++;
      return r;
   endfunction

   task automatic send_request(logic [2:0] func, logic [ipq_pkg::IDX_W-1:0] idx,
                               logic [ipq_pkg::KEY_W-1:0] key, bit typed,
                               ipq_pkg::rsp_type typed_rsp);
      int gap;
      start <= 1'b1;
      req_data <= '{func: func, entry_index: idx, entry_key: key};
      @(posedge clock);
      while (busy) @(posedge clock);
      results_due.push_back(heap_apply(func, idx, key));
      typed_due.push_back(typed_rsp);
      typed_flag.push_back(typed);
      requests_done++;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         req_data <= '{func: 3'($urandom), entry_index: ipq_pkg::IDX_W'($urandom),
                       entry_key: $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void compare(ipq_pkg::rsp_type want, ipq_pkg::rsp_type got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected key %h idx %0d cnt %0d pres %0d err %0d,",
                      " got key %h idx %0d cnt %0d pres %0d err %0d"},
                     want.top_key, want.top_index, want.entry_count, want.is_present,
                     want.error_code, got.top_key, got.top_index, got.entry_count,
                     got.is_present, got.error_code);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result with no request outstanding");
         end else begin
            compare(results_due.pop_front(), rsp_data);
            if (typed_flag.pop_front()) compare(typed_due[0], rsp_data);
            void'(typed_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic ipq_pkg::rsp_type mk(logic [ipq_pkg::KEY_W-1:0] k,
                                           logic [ipq_pkg::IDX_W-1:0] i, int c,
                                           bit p, ipq_pkg::err_type e);
      return '{top_key: k, top_index: i, entry_count: c[ipq_pkg::CNT_W-1:0],
               is_present: p, error_code: e};
   endfunction

   row_type directed[$];

   function automatic void add_row(logic [2:0] f, logic [ipq_pkg::IDX_W-1:0] i,
                                   logic [ipq_pkg::KEY_W-1:0] k,
                                   bit t = 0, ipq_pkg::rsp_type r = '0);
      row_type row;
      row.func = f; row.idx = i; row.key = k; row.typed = t; row.rsp = r;
      directed.push_back(row);
   endfunction

   initial begin
      int                        i;
      int                        n;
      int                        mode;
      logic [2:0]                f;
      logic [ipq_pkg::IDX_W-1:0] ix;
      logic [ipq_pkg::KEY_W-1:0] k;
      for (i = 0; i < ipq_pkg::QSIZE; i++) begin
         key_of[i] = '0; slot_of[i] = '0; pos_of[i] = 0;
      end
      slot_of[ipq_pkg::QSIZE] = '0;
      live = 0;
      for (i = 0; i < 8; i++) err_hits[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(ipq_pkg::FUNC_QUERY, 6'd0, 32'h0, 1, mk(0, 0, 0, 0, ipq_pkg::ERR_OK));
      add_row(ipq_pkg::FUNC_REMOVE_MAX, 6'd5, 32'h0, 1, mk(0, 0, 0, 0, ipq_pkg::ERR_EMPTY));
      add_row(ipq_pkg::FUNC_CHANGE, 6'd63, 32'h1, 1, mk(0, 0, 0, 0, ipq_pkg::ERR_ABSENT));
      add_row(ipq_pkg::FUNC_REMOVE_IDX, 6'd7, 32'h1, 1,
              mk(0, 0, 0, 0, ipq_pkg::ERR_ABSENT));
      add_row(ipq_pkg::FUNC_INSERT, 6'd63, 32'hFFFF_FFFF, 1,
              mk(32'hFFFF_FFFF, 63, 1, 1, ipq_pkg::ERR_OK));
      add_row(ipq_pkg::FUNC_INSERT, 6'd0, 32'h0, 1,
              mk(32'hFFFF_FFFF, 63, 2, 1, ipq_pkg::ERR_OK));
      add_row(ipq_pkg::FUNC_INSERT, 6'd0, 32'h5, 1,
              mk(32'hFFFF_FFFF, 63, 2, 1, ipq_pkg::ERR_PRESENT));
      add_row(ipq_pkg::FUNC_INSERT, 6'd21, 32'hFFFF_FFFF);
      add_row(ipq_pkg::FUNC_INSERT, 6'd42, 32'h8000_0000);
      add_row(ipq_pkg::FUNC_CHANGE, 6'd0, 32'hFFFF_FFFF);
      add_row(ipq_pkg::FUNC_CHANGE, 6'd63, 32'h0);
      add_row(FUNC_SPARE, 6'd42, 32'h0);
      add_row(FUNC_TOP_CODE, 6'd1, 32'h0);
      add_row(ipq_pkg::FUNC_REMOVE_IDX, 6'd42, 32'h0);
      add_row(ipq_pkg::FUNC_REMOVE_MAX, 6'd0, 32'h0);
      add_row(ipq_pkg::FUNC_REMOVE_IDX, 6'd63, 32'h0);
      add_row(ipq_pkg::FUNC_REMOVE_MAX, 6'd0, 32'h0);
      add_row(ipq_pkg::FUNC_REMOVE_MAX, 6'd0, 32'h0, 1, mk(0, 0, 0, 0, ipq_pkg::ERR_EMPTY));
      foreach (directed[j])
         send_request(directed[j].func, directed[j].idx, directed[j].key,
                      directed[j].typed, directed[j].rsp);

      // fill to capacity, probe full, then drain
      for (i = 0; i < ipq_pkg::QSIZE; i++)
         send_request(ipq_pkg::FUNC_INSERT, ipq_pkg::IDX_W'(i), $urandom_range(0, 40), 0, '0);
      send_request(ipq_pkg::FUNC_INSERT, 6'd9, 32'h7, 0, '0);
      for (i = 0; i < 20; i++)
         send_request(ipq_pkg::FUNC_CHANGE, ipq_pkg::IDX_W'($urandom), $urandom, 0, '0);
      for (i = 0; i < ipq_pkg::QSIZE; i++)
         send_request(ipq_pkg::FUNC_REMOVE_MAX, ipq_pkg::IDX_W'($urandom), '0, 0, '0);

      // random phases, each biased at random toward growth, shrink or a mix
      n = 0;
      while (n < NUM_RANDOM) begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 60)) begin
            ix = ipq_pkg::IDX_W'($urandom);
            k = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
            if ($urandom_range(0, 3) == 0)
               k = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            case ($urandom_range(0, 9))
               0, 1, 2: f = (mode == 1) ? ipq_pkg::FUNC_REMOVE_MAX : ipq_pkg::FUNC_INSERT;
               3, 4:    f = ipq_pkg::FUNC_CHANGE;
               5:       f = ipq_pkg::FUNC_REMOVE_MAX;
               6, 7:    f = (mode == 0) ? ipq_pkg::FUNC_INSERT : ipq_pkg::FUNC_REMOVE_IDX;
               8:       f = ipq_pkg::FUNC_QUERY;
               default: f = 3'($urandom_range(0, 7));
            endcase
            send_request(f, ix, k, 0, '0);
            n++;
         end
      end
      start <= 1'b0;

      n = 0;
      while (results_due.size() != 0 && n < 200) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
      $display("ran %0d requests, %0d results; errors seen: ok %0d full %0d present %0d",
               requests_done, results_seen, err_hits[ipq_pkg::ERR_OK],
               err_hits[ipq_pkg::ERR_FULL], err_hits[ipq_pkg::ERR_PRESENT]);
      $display("absent %0d empty %0d; mismatches: %0d",
               err_hits[ipq_pkg::ERR_ABSENT], err_hits[ipq_pkg::ERR_EMPTY], mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
